// ----- design/fcfa_pkg.sv -----
// fcfa_pkg: shared widths, codes, marks and control structs of the chain analyser
`timescale 1ns / 1ps
package fcfa_pkg;

    localparam int ENTRY_W = 28;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 13;
    localparam int TALLY_W = 16;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WALK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CENSUS = 2'd2;

    localparam logic KIND_WALK   = 1'b0;
    localparam logic KIND_CENSUS = 1'b1;

    localparam logic [ENTRY_W-1:0] MARK_FREE        = 28'h0000000;
    localparam logic [ENTRY_W-1:0] MARK_BAD         = 28'hFFFFFF7;
    localparam logic [ENTRY_W-1:0] MARK_END_MIN     = 28'hFFFFFF8;
    localparam logic [ENTRY_W-1:0] DATA_CLUSTER_MIN = 28'd2;
    localparam logic [TALLY_W-1:0] TALLY_MAX        = 16'hFFFF;

    // commands from the controller to the datapath
    typedef struct packed {
        logic wr_entry;
        logic walk_start;
        logic walk_step;
        logic cen_start;
        logic cen_step;
        logic emit;
        logic emit_kind;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic start_low;
        logic cen_empty;
        logic walk_last;
        logic cen_last;
    } t_dp_status;

endpackage

// ----- design/fcfa_in_if.sv -----
// fcfa_in_if: input word channel, command plus table address and entry
`timescale 1ns / 1ps
interface fcfa_in_if;
    logic                          valid;
    logic                          ready;
    logic [fcfa_pkg::CMD_W-1:0]    cmd;
    logic [fcfa_pkg::ENTRY_W-1:0]  cluster_index;
    logic [fcfa_pkg::ENTRY_W-1:0]  entry_value;

    modport source (output valid, cmd, cluster_index, entry_value, input ready);
    modport sink   (input valid, cmd, cluster_index, entry_value, output ready);
endinterface

// ----- design/fcfa_out_if.sv -----
// fcfa_out_if: result word channel, walk or census figures
`timescale 1ns / 1ps
interface fcfa_out_if;
    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [fcfa_pkg::COUNT_W-1:0]  fragment_total;
    logic [fcfa_pkg::COUNT_W-1:0]  chain_clusters;
    logic [fcfa_pkg::TALLY_W-1:0]  free_count;
    logic [fcfa_pkg::TALLY_W-1:0]  bad_count;
    logic [fcfa_pkg::TALLY_W-1:0]  used_count;

    modport source (output valid, result_kind, fragment_total, chain_clusters,
                    free_count, bad_count, used_count, input ready);
    modport sink   (input valid, result_kind, fragment_total, chain_clusters,
                    free_count, bad_count, used_count, output ready);
endinterface

// ----- design/fcfa_ram.sv -----
// fcfa_ram: generic single-port RAM with registered read
`timescale 1ns / 1ps
module fcfa_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/fcfa_ctrl.sv -----
// fcfa_ctrl: sequencing state machine and handshake control of the analyser
`timescale 1ns / 1ps
module fcfa_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [fcfa_pkg::CMD_W-1:0] i_in_cmd,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  fcfa_pkg::t_dp_status       i_status,
    output fcfa_pkg::t_dp_cmd          o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_CEN    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_kind, n_kind;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_cmd)
                        fcfa_pkg::CMD_WRITE: begin
                            o_cmd.wr_entry = 1'b1;
                        end
                        fcfa_pkg::CMD_WALK: begin
                            o_cmd.walk_start = 1'b1;
                            n_kind  = fcfa_pkg::KIND_WALK;
                            n_state = i_status.start_low ? S_FINISH : S_WALK;
                        end
                        fcfa_pkg::CMD_CENSUS: begin
                            o_cmd.cen_start = 1'b1;
                            n_kind  = fcfa_pkg::KIND_CENSUS;
                            n_state = i_status.cen_empty ? S_FINISH : S_CEN;
                        end
                        default: begin
                            // unknown command is dropped
                        end
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_FINISH;
                end
            end
            S_CEN: begin
                o_cmd.cen_step = 1'b1;
                if (i_status.cen_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = r_kind;
                    n_out_valid     = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= fcfa_pkg::KIND_WALK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

// ----- design/fcfa_dpath.sv -----
// fcfa_dpath: allocation table, walk and census counters, result register
`timescale 1ns / 1ps
module fcfa_dpath #(
    parameter int TABLE_ENTRIES = 65536,
    parameter int MAX_CHAIN     = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [fcfa_pkg::ENTRY_W-1:0] i_cfg_wdata,
    input  logic [fcfa_pkg::ENTRY_W-1:0] i_cluster_index,
    input  logic [fcfa_pkg::ENTRY_W-1:0] i_entry_value,
    input  fcfa_pkg::t_dp_cmd            i_cmd,
    output fcfa_pkg::t_dp_status         o_status,
    output logic                         o_result_kind,
    output logic [fcfa_pkg::COUNT_W-1:0] o_fragment_total,
    output logic [fcfa_pkg::COUNT_W-1:0] o_chain_clusters,
    output logic [fcfa_pkg::TALLY_W-1:0] o_free_count,
    output logic [fcfa_pkg::TALLY_W-1:0] o_bad_count,
    output logic [fcfa_pkg::TALLY_W-1:0] o_used_count
);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int PW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = $clog2(MAX_CHAIN + 2);
    localparam int EW = fcfa_pkg::ENTRY_W;
    localparam int TW = fcfa_pkg::TALLY_W;

    logic [EW-1:0] r_vol;
    logic [EW-1:0] r_cluster, n_cluster;
    logic [SW-1:0] r_steps, n_steps;
    logic [SW-1:0] r_frag, n_frag;
    logic          r_oor, n_oor;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_limit, n_limit;
    logic [TW-1:0] r_free, n_free;
    logic [TW-1:0] r_bad, n_bad;
    logic [TW-1:0] r_used, n_used;

    logic                             r_res_kind;
    logic [fcfa_pkg::COUNT_W-1:0]     r_res_frag, r_res_chain;
    logic [TW-1:0]                    r_res_free, r_res_bad, r_res_used;

    logic [EW-1:0] rdata;
    logic [EW-1:0] link;
    logic          link_term;
    logic          idx_in_range;
    logic          link_in_range;
    logic [PW-1:0] limit_calc;
    logic [PW-1:0] pos_next;
    logic [AW-1:0] ram_addr;
    logic          ram_we;

    assign idx_in_range  = i_cluster_index < EW'(TABLE_ENTRIES);
    assign link_in_range = link < EW'(TABLE_ENTRIES);

    // entries past the table read as free
    assign link      = r_oor ? fcfa_pkg::MARK_FREE : rdata;
    assign link_term = (link >= fcfa_pkg::MARK_END_MIN) || (link == fcfa_pkg::MARK_FREE)
                       || (link == fcfa_pkg::MARK_BAD);

    assign limit_calc = (r_vol >= EW'(TABLE_ENTRIES)) ? PW'(TABLE_ENTRIES) : PW'(r_vol);
    assign pos_next   = r_pos + PW'(1);

    assign o_status.start_low = i_cluster_index < fcfa_pkg::DATA_CLUSTER_MIN;
    assign o_status.cen_empty = limit_calc <= PW'(fcfa_pkg::DATA_CLUSTER_MIN);
    assign o_status.walk_last = link_term || (r_steps == SW'(MAX_CHAIN));
    assign o_status.cen_last  = pos_next >= r_limit;

    always_comb begin
        ram_addr = i_cluster_index[AW-1:0];
        if (i_cmd.walk_step) begin
            ram_addr = link[AW-1:0];
        end else if (i_cmd.cen_start) begin
            ram_addr = AW'(fcfa_pkg::DATA_CLUSTER_MIN);
        end else if (i_cmd.cen_step) begin
            ram_addr = pos_next[AW-1:0];
        end
    end

    assign ram_we = i_cmd.wr_entry && idx_in_range;

    fcfa_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_entry_value),
        .o_rdata (rdata)
    );

    always_comb begin
        n_cluster = r_cluster;
        n_steps   = r_steps;
        n_frag    = r_frag;
        n_oor     = r_oor;
        n_pos     = r_pos;
        n_limit   = r_limit;
        n_free    = r_free;
        n_bad     = r_bad;
        n_used    = r_used;
        if (i_cmd.walk_start) begin
            n_cluster = i_cluster_index;
            n_oor     = !idx_in_range;
            n_steps   = o_status.start_low ? '0 : SW'(1);
            n_frag    = o_status.start_low ? '0 : SW'(1);
        end
        if (i_cmd.walk_step && !link_term) begin
            // a link that is not the next cluster opens a new run
            if ({1'b0, link} != ({1'b0, r_cluster} + (EW + 1)'(1))) begin
                n_frag = r_frag + SW'(1);
            end
            n_cluster = link;
            n_steps   = r_steps + SW'(1);
            n_oor     = !link_in_range;
        end
        if (i_cmd.cen_start) begin
            n_pos   = PW'(fcfa_pkg::DATA_CLUSTER_MIN);
            n_limit = limit_calc;
            n_free  = '0;
            n_bad   = '0;
            n_used  = '0;
        end
        if (i_cmd.cen_step) begin
            n_pos = pos_next;
            if (rdata == fcfa_pkg::MARK_FREE) begin
                n_free = (r_free == fcfa_pkg::TALLY_MAX) ? r_free : r_free + TW'(1);
            end else if (rdata == fcfa_pkg::MARK_BAD) begin
                n_bad = (r_bad == fcfa_pkg::TALLY_MAX) ? r_bad : r_bad + TW'(1);
            end else begin
                n_used = (r_used == fcfa_pkg::TALLY_MAX) ? r_used : r_used + TW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol     <= '0;
            r_cluster <= '0;
            r_steps   <= '0;
            r_frag    <= '0;
            r_oor     <= 1'b0;
            r_pos     <= '0;
            r_limit   <= '0;
            r_free    <= '0;
            r_bad     <= '0;
            r_used    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_vol <= i_cfg_wdata;
            end
            r_cluster <= n_cluster;
            r_steps   <= n_steps;
            r_frag    <= n_frag;
            r_oor     <= n_oor;
            r_pos     <= n_pos;
            r_limit   <= n_limit;
            r_free    <= n_free;
            r_bad     <= n_bad;
            r_used    <= n_used;
        end
    end

    // result word, unused fields of each kind read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res_kind <= i_cmd.emit_kind;
            if (i_cmd.emit_kind == fcfa_pkg::KIND_WALK) begin
                r_res_frag  <= fcfa_pkg::COUNT_W'(r_frag);
                r_res_chain <= fcfa_pkg::COUNT_W'(r_steps);
                r_res_free  <= '0;
                r_res_bad   <= '0;
                r_res_used  <= '0;
            end else begin
                r_res_frag  <= '0;
                r_res_chain <= '0;
                r_res_free  <= r_free;
                r_res_bad   <= r_bad;
                r_res_used  <= r_used;
            end
        end
    end

    assign o_result_kind    = r_res_kind;
    assign o_fragment_total = r_res_frag;
    assign o_chain_clusters = r_res_chain;
    assign o_free_count     = r_res_free;
    assign o_bad_count      = r_res_bad;
    assign o_used_count     = r_res_used;
endmodule

// ----- design/fat_chain_fragment_analyzer.sv -----
// a table write is taken in S_IDLE; a walk reads its start entry on acceptance,
// then one table read per lookup in S_WALK, at most MAX_CHAIN lookups; a census
// counts entries 2 to min(volume_clusters, TABLE_ENTRIES) - 1, one entry per cycle
// throughput: one write per cycle, walks and census one at a time on the table port
// reset (synchronous, active low) clears control, counters and volume_clusters;
// table contents are undefined until written, there is no clearing pass
`timescale 1ns / 1ps
module fat_chain_fragment_analyzer #(
    parameter int TABLE_ENTRIES = 65536,
    parameter int MAX_CHAIN     = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fcfa_in_if.sink                       i_item,
    fcfa_out_if.source                    o_res,
    input  logic                          i_cfg_we,
    input  logic [fcfa_pkg::ENTRY_W-1:0]  i_cfg_wdata
);
    fcfa_pkg::t_dp_cmd    dp_cmd;
    fcfa_pkg::t_dp_status dp_status;

    fcfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_cmd    (i_item.cmd),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    fcfa_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CHAIN     (MAX_CHAIN)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_cluster_index  (i_item.cluster_index),
        .i_entry_value    (i_item.entry_value),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_result_kind    (o_res.result_kind),
        .o_fragment_total (o_res.fragment_total),
        .o_chain_clusters (o_res.chain_clusters),
        .o_free_count     (o_res.free_count),
        .o_bad_count      (o_res.bad_count),
        .o_used_count     (o_res.used_count)
    );
endmodule

// ----- design/fcfa_checker.sv -----
// fcfa_checker: port-level assertions on the analyser, bound to the top level
`timescale 1ns / 1ps
module fcfa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_result_kind,
    input logic [fcfa_pkg::COUNT_W-1:0] i_fragment_total,
    input logic [fcfa_pkg::COUNT_W-1:0] i_chain_clusters,
    input logic [fcfa_pkg::TALLY_W-1:0] i_free_count,
    input logic [fcfa_pkg::TALLY_W-1:0] i_bad_count,
    input logic [fcfa_pkg::TALLY_W-1:0] i_used_count
);
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result_kind)
            && $stable(i_chain_clusters) && $stable(i_free_count))
        else $error("stalled result word changed");

    a_walk_no_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_kind == fcfa_pkg::KIND_WALK) |->
            (i_free_count == '0) && (i_bad_count == '0) && (i_used_count == '0))
        else $error("walk result carries census tallies");

    a_census_no_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_result_kind == fcfa_pkg::KIND_CENSUS) |->
            (i_fragment_total == '0) && (i_chain_clusters == '0))
        else $error("census result carries chain figures");
endmodule

bind fat_chain_fragment_analyzer fcfa_checker u_fcfa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_result_kind    (o_res.result_kind),
    .i_fragment_total (o_res.fragment_total),
    .i_chain_clusters (o_res.chain_clusters),
    .i_free_count     (o_res.free_count),
    .i_bad_count      (o_res.bad_count),
    .i_used_count     (o_res.used_count)
);

// ----- verif/tb_fat_chain_fragment_analyzer.sv -----
// tb_fat_chain_fragment_analyzer: self-checking bench for the fat chain fragment analyser
`timescale 1ns / 1ps
module tb_fat_chain_fragment_analyzer;

    localparam int      TABLE_ENTRIES = 65536;
    localparam int      MAX_CHAIN     = 4096;
    localparam int      REGION        = 512;
    localparam int      CLK_PERIOD    = 10;
    localparam int      RESET_CYCLES  = 7;
    localparam int      SETTLE_CYCLES = 8;
    localparam int      HOLD_CYCLES   = 400;
    localparam longint  TIMEOUT_NS    = 500_000_000;

    localparam logic [fcfa_pkg::CMD_W-1:0]   CMD_UNUSED   = 2'd3;
    localparam logic [fcfa_pkg::ENTRY_W-1:0] BAD_MARK     = 28'hFFFFFF7;
    localparam logic [fcfa_pkg::ENTRY_W-1:0] END_MARK_LOW = 28'hFFFFFF8;
    localparam logic [fcfa_pkg::ENTRY_W-1:0] END_MARK_TOP = 28'hFFFFFFF;

    typedef struct packed {
        logic                         kind;
        logic [fcfa_pkg::COUNT_W-1:0] runs;
        logic [fcfa_pkg::COUNT_W-1:0] lookups;
        logic [fcfa_pkg::TALLY_W-1:0] free_n;
        logic [fcfa_pkg::TALLY_W-1:0] bad_n;
        logic [fcfa_pkg::TALLY_W-1:0] used_n;
    } t_fat_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [fcfa_pkg::ENTRY_W-1:0] i_cfg_wdata;

    fcfa_in_if  item_if ();
    fcfa_out_if res_if ();

    fat_chain_fragment_analyzer #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CHAIN     (MAX_CHAIN)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mirror of the table and the volume size
    bit   [fcfa_pkg::ENTRY_W-1:0] fat_mirror [TABLE_ENTRIES];
    logic [fcfa_pkg::ENTRY_W-1:0] volume_mirror;
    t_fat_result                  pending_results [$];

    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int unsigned hold_req_seq   = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [fcfa_pkg::ENTRY_W-1:0] mirror_read(
            input logic [fcfa_pkg::ENTRY_W-1:0] idx);
        if (idx >= TABLE_ENTRIES) return '0;
        return fat_mirror[idx];
    endfunction

    function automatic t_fat_result follow_chain(input logic [fcfa_pkg::ENTRY_W-1:0] start);
        t_fat_result                  r;
        logic [fcfa_pkg::ENTRY_W-1:0] here;
        logic [fcfa_pkg::ENTRY_W-1:0] link;
        int unsigned                  runs;
        int unsigned                  lookups;
        r = '0;
        r.kind = fcfa_pkg::KIND_WALK;
        if (start < fcfa_pkg::DATA_CLUSTER_MIN) return r;
        here = start;
        runs = 1;
        lookups = 0;
        forever begin
            lookups++;
            if (lookups > MAX_CHAIN) break;
            link = mirror_read(here);
            if (link >= END_MARK_LOW || link == '0 || link == BAD_MARK) break;
            if (32'(link) != 32'(here) + 1) runs++;
            here = link;
        end
        r.runs = runs[fcfa_pkg::COUNT_W-1:0];
        r.lookups = lookups[fcfa_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic t_fat_result tally_table();
        t_fat_result                  r;
        int unsigned                  limit;
        logic [fcfa_pkg::ENTRY_W-1:0] v;
        r = '0;
        r.kind = fcfa_pkg::KIND_CENSUS;
        limit = (volume_mirror > TABLE_ENTRIES) ? TABLE_ENTRIES : volume_mirror;
        for (int unsigned pos = 2; pos < limit; pos++) begin
            v = fat_mirror[pos];
            if (v == '0) begin
                if (r.free_n != fcfa_pkg::TALLY_MAX) r.free_n++;
            end else if (v == BAD_MARK) begin
                if (r.bad_n != fcfa_pkg::TALLY_MAX) r.bad_n++;
            end else begin
                if (r.used_n != fcfa_pkg::TALLY_MAX) r.used_n++;
            end
        end
        return r;
    endfunction

    function automatic void apply_item(input logic [fcfa_pkg::CMD_W-1:0] cmd,
                                       input logic [fcfa_pkg::ENTRY_W-1:0] idx,
                                       input logic [fcfa_pkg::ENTRY_W-1:0] val);
        case (cmd)
            fcfa_pkg::CMD_WRITE: begin
                if (idx < TABLE_ENTRIES) fat_mirror[idx] = val;
            end
            fcfa_pkg::CMD_WALK:   pending_results.push_back(follow_chain(idx));
            fcfa_pkg::CMD_CENSUS: pending_results.push_back(tally_table());
            default: ;
        endcase
    endfunction

    // random entry: links stay inside the loaded region or jump past the table
    function automatic logic [fcfa_pkg::ENTRY_W-1:0] link_value(
            input logic [fcfa_pkg::ENTRY_W-1:0] idx);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return '0;
        if (pick < 18) return BAD_MARK;
        if (pick < 30) return END_MARK_LOW + fcfa_pkg::ENTRY_W'($urandom_range(0, 7));
        if (pick < 70) begin
            if (32'(idx) + 1 < REGION) return idx + 1'b1;
            return '0;
        end
        if (pick < 90) return fcfa_pkg::ENTRY_W'($urandom_range(0, REGION - 1));
        return fcfa_pkg::ENTRY_W'($urandom_range(32'h0FFFFFFF, TABLE_ENTRIES));
    endfunction

    task automatic send_item(input logic [fcfa_pkg::CMD_W-1:0] cmd,
                             input logic [fcfa_pkg::ENTRY_W-1:0] idx,
                             input logic [fcfa_pkg::ENTRY_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_if.valid         <= 1'b1;
        item_if.cmd           <= cmd;
        item_if.cluster_index <= idx;
        item_if.entry_value   <= val;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        apply_item(cmd, idx, val);
    endtask

    // block is idle once every result is in and a write has had time to land
    task automatic settle_block();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_volume(input logic [fcfa_pkg::ENTRY_W-1:0] clusters);
        settle_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= clusters;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        volume_mirror = clusters;
    endtask

    task automatic send_random_item();
        int unsigned                  pick;
        logic [fcfa_pkg::ENTRY_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 9) == 0)
                idx = fcfa_pkg::ENTRY_W'($urandom_range(32'h0FFFFFFF, TABLE_ENTRIES));
            else idx = fcfa_pkg::ENTRY_W'($urandom_range(0, REGION - 1));
            send_item(fcfa_pkg::CMD_WRITE, idx, link_value(idx));
        end else if (pick < 80) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) idx = fcfa_pkg::ENTRY_W'($urandom_range(0, 1));
            else if (pick < 15)
                idx = fcfa_pkg::ENTRY_W'($urandom_range(32'h0FFFFFFF, TABLE_ENTRIES));
            else idx = fcfa_pkg::ENTRY_W'($urandom_range(2, REGION - 1));
            send_item(fcfa_pkg::CMD_WALK, idx, fcfa_pkg::ENTRY_W'($urandom()));
        end else if (pick < 92) begin
            send_item(fcfa_pkg::CMD_CENSUS, fcfa_pkg::ENTRY_W'($urandom()),
                      fcfa_pkg::ENTRY_W'($urandom()));
        end else begin
            send_item(CMD_UNUSED, fcfa_pkg::ENTRY_W'($urandom()),
                      fcfa_pkg::ENTRY_W'($urandom()));
        end
    endtask

    // the working region gets written once so walks and census read only loaded words
    task automatic test_table_load();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < REGION; i++)
            send_item(fcfa_pkg::CMD_WRITE, fcfa_pkg::ENTRY_W'(i),
                      link_value(fcfa_pkg::ENTRY_W'(i)));
        settle_block();
    endtask

    task automatic test_boundary_walks();
        // writes past the table are dropped, reads there give free
        send_item(fcfa_pkg::CMD_WRITE, END_MARK_TOP, 28'd100);
        send_item(fcfa_pkg::CMD_WRITE, fcfa_pkg::ENTRY_W'(TABLE_ENTRIES), 28'd101);
        send_item(fcfa_pkg::CMD_WALK, 28'd0, '0);
        send_item(fcfa_pkg::CMD_WALK, 28'd1, '0);
        send_item(fcfa_pkg::CMD_WALK, END_MARK_TOP, END_MARK_TOP);
        send_item(fcfa_pkg::CMD_WALK, fcfa_pkg::ENTRY_W'(TABLE_ENTRIES), '0);
        // contiguous run ending on the top end mark
        send_item(fcfa_pkg::CMD_WRITE, 28'd100, 28'd101);
        send_item(fcfa_pkg::CMD_WRITE, 28'd101, 28'd102);
        send_item(fcfa_pkg::CMD_WRITE, 28'd102, END_MARK_TOP);
        send_item(fcfa_pkg::CMD_WALK, 28'd100, '0);
        send_item(fcfa_pkg::CMD_WRITE, 28'd110, END_MARK_LOW);
        send_item(fcfa_pkg::CMD_WALK, 28'd110, '0);
        // jump then bad mark
        send_item(fcfa_pkg::CMD_WRITE, 28'd120, 28'd130);
        send_item(fcfa_pkg::CMD_WRITE, 28'd130, BAD_MARK);
        send_item(fcfa_pkg::CMD_WALK, 28'd120, '0);
        send_item(fcfa_pkg::CMD_WRITE, 28'd140, 28'd141);
        send_item(fcfa_pkg::CMD_WRITE, 28'd141, 28'd0);
        send_item(fcfa_pkg::CMD_WALK, 28'd140, '0);
        // a 24-bit lookalike of the bad mark is an ordinary link past the table
        send_item(fcfa_pkg::CMD_WRITE, 28'd150, 28'h0FFFFF7);
        send_item(fcfa_pkg::CMD_WALK, 28'd150, '0);
        // two-entry loop trips the length guard
        send_item(fcfa_pkg::CMD_WRITE, 28'd170, 28'd171);
        send_item(fcfa_pkg::CMD_WRITE, 28'd171, 28'd170);
        send_item(fcfa_pkg::CMD_WALK, 28'd170, '0);
        send_item(CMD_UNUSED, 28'd100, 28'd0);
        send_item(fcfa_pkg::CMD_WALK, 28'd100, '0);
        settle_block();
    endtask

    task automatic census_walk_at(input logic [fcfa_pkg::ENTRY_W-1:0] clusters);
        set_volume(clusters);
        send_item(fcfa_pkg::CMD_CENSUS, fcfa_pkg::ENTRY_W'($urandom()),
                  fcfa_pkg::ENTRY_W'($urandom()));
    endtask

    task automatic test_census_limits();
        census_walk_at(28'd0);
        census_walk_at(28'd1);
        census_walk_at(28'd2);
        census_walk_at(28'd3);
        census_walk_at(fcfa_pkg::ENTRY_W'(REGION - 1));
        census_walk_at(fcfa_pkg::ENTRY_W'(REGION));
        settle_block();
    endtask

    // result side holds off while words keep coming, so the input backs up
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_volume(28'd40);
        hold_req_seq++;
        for (int i = 0; i < 60; i++) begin
            case (i % 3)
                0: send_item(fcfa_pkg::CMD_WALK,
                             fcfa_pkg::ENTRY_W'($urandom_range(2, REGION - 1)), '0);
                1: send_item(fcfa_pkg::CMD_CENSUS, '0, '0);
                default: send_item(fcfa_pkg::CMD_WRITE,
                                   fcfa_pkg::ENTRY_W'($urandom_range(2, 39)),
                                   link_value(fcfa_pkg::ENTRY_W'(i)));
            endcase
        end
        settle_block();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int done;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_items) begin
            set_volume(fcfa_pkg::ENTRY_W'($urandom_range(0, REGION)));
            for (int k = 0; k < 150 && done < n_items; k++) begin
                send_random_item();
                done++;
            end
        end
        settle_block();
    endtask

    // result ready, with a long hold-off on request
    always @(posedge i_clk) begin : res_ready_drive
        int unsigned hold_seen_seq;
        int          hold_left;
        if (hold_req_seq != hold_seen_seq) begin
            hold_seen_seq = hold_req_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic compare_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_fat_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, kind %0d",
                                          res_if.result_kind));
            end else begin
                want = pending_results.pop_front();
                compare_field("result_kind", res_if.result_kind, want.kind);
                compare_field("fragment_total", res_if.fragment_total, want.runs);
                compare_field("chain_clusters", res_if.chain_clusters, want.lookups);
                compare_field("free_count", res_if.free_count, want.free_n);
                compare_field("bad_count", res_if.bad_count, want.bad_n);
                compare_field("used_count", res_if.used_count, want.used_n);
            end
        end
    end

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_wdata           <= '0;
        item_if.valid         <= 1'b0;
        item_if.cmd           <= fcfa_pkg::CMD_WRITE;
        item_if.cluster_index <= '0;
        item_if.entry_value   <= '0;
        volume_mirror = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_load();
        test_boundary_walks();
        test_census_limits();
        test_output_backpressure();
        test_random_traffic(0, 0, 350);
        test_random_traffic(86, 0, 300);
        test_random_traffic(0, 86, 300);
        test_random_traffic(36, 36, 350);
        settle_block();

        if (mismatch_count == 0) begin
            $display("** fat_chain_fragment_analyzer: PASSED **");
        end else begin
            $display("** fat_chain_fragment_analyzer: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** fat_chain_fragment_analyzer: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
design/fcfa_pkg.sv
design/fcfa_in_if.sv
design/fcfa_out_if.sv
design/fcfa_ram.sv
design/fcfa_ctrl.sv
design/fcfa_dpath.sv
design/fat_chain_fragment_analyzer.sv
design/fcfa_checker.sv
verif/tb_fat_chain_fragment_analyzer.sv
